>>> sv/sct_pkg.sv
// types, token kinds and keyword table shared by the tokenizer modules
`default_nettype none

package sct_pkg;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       final_byte;
  } sct_in_t;

  typedef struct packed {
    logic [5:0] token_kind;
    logic [7:0] lexeme_value;
    logic       last_of_run;
  } sct_out_t;

  localparam int SCT_MAX_RES = 3;

  typedef struct packed {
    logic [1:0]                    count;
    sct_out_t [SCT_MAX_RES-1:0]    res;
  } sct_batch_t;

  localparam int SCT_QUEUE_DEPTH = 4;
  localparam int SCT_QPTR_W      = 2;
  localparam int SCT_QCNT_W      = 3;

  localparam logic [5:0] K_LEXEME     = 6'd0;
  localparam logic [5:0] K_PLUS       = 6'd1;
  localparam logic [5:0] K_MINUS      = 6'd2;
  localparam logic [5:0] K_STAR       = 6'd3;
  localparam logic [5:0] K_SLASH      = 6'd4;
  localparam logic [5:0] K_LPAREN     = 6'd5;
  localparam logic [5:0] K_RPAREN     = 6'd6;
  localparam logic [5:0] K_LBRACE     = 6'd7;
  localparam logic [5:0] K_RBRACE     = 6'd8;
  localparam logic [5:0] K_LESS       = 6'd9;
  localparam logic [5:0] K_LESS_EQ    = 6'd10;
  localparam logic [5:0] K_GREATER    = 6'd11;
  localparam logic [5:0] K_GREATER_EQ = 6'd12;
  localparam logic [5:0] K_NOT        = 6'd13;
  localparam logic [5:0] K_NOT_EQ     = 6'd14;
  localparam logic [5:0] K_EQUAL      = 6'd15;
  localparam logic [5:0] K_EQUAL_EQ   = 6'd16;
  localparam logic [5:0] K_DOT        = 6'd17;
  localparam logic [5:0] K_COLON      = 6'd18;
  localparam logic [5:0] K_SEMI       = 6'd19;
  localparam logic [5:0] K_CHAR       = 6'd20;
  localparam logic [5:0] K_STRING     = 6'd21;
  localparam logic [5:0] K_IDENT      = 6'd22;
  localparam logic [5:0] K_NUMBER     = 6'd23;
  localparam logic [5:0] K_KW0        = 6'd24;
  localparam logic [5:0] K_ERROR      = 6'd41;

  localparam int SCT_NUM_KW = 17;

  // keyword text, first character in the low byte
  function automatic logic [47:0] kw_text(input logic [4:0] k);
    logic [47:0] t;
    case (k)
      5'd0:    t = 48'h000065736163;  // case
      5'd1:    t = 48'h0074736e6f63;  // const
      5'd2:    t = 48'h000000666564;  // def
      5'd3:    t = 48'h000000006669;  // if
      5'd4:    t = 48'h666965736c65;  // elseif
      5'd5:    t = 48'h000065736c65;  // else
      5'd6:    t = 48'h000000726f66;  // for
      5'd7:    t = 48'h000000006e66;  // fn
      5'd8:    t = 48'h686374697773;  // switch
      5'd9:    t = 48'h00656c696877;  // while
      5'd10:   t = 48'h0000706f6f6c;  // loop
      5'd11:   t = 48'h000065757274;  // true
      5'd12:   t = 48'h0065736c6166;  // false
      5'd13:   t = 48'h000000746e69;  // int
      5'd14:   t = 48'h000072616863;  // char
      5'd15:   t = 48'h00006c6f6f62;  // bool
      5'd16:   t = 48'h000000727473;  // str
      default: t = 48'h0;
    endcase
    return t;
  endfunction

  // closing kind of an identifier; bytes beyond the length are zero
  function automatic logic [5:0] ident_kind(input logic [47:0] kbuf,
                                            input logic [2:0]  klen);
    logic [5:0] kind;
    kind = K_IDENT;
    if (klen <= 3'd6) begin
      for (int k = SCT_NUM_KW - 1; k >= 0; k--) begin
        if (kbuf == kw_text(5'(k))) begin
          kind = K_KW0 + 6'(k);
        end
      end
    end
    return kind;
  endfunction

endpackage

`default_nettype wire

>>> sv/sct_lexer.sv
// scanner state and per-byte token decoding into a batch of result words
`default_nettype none

module sct_lexer (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire sct_pkg::sct_in_t   item,
  output sct_pkg::sct_batch_t     batch
);
  import sct_pkg::*;

  typedef enum logic [10:0] {
    MODE_IDLE    = 11'b000_0000_0001,
    MODE_IDENT   = 11'b000_0000_0010,
    MODE_NUM     = 11'b000_0000_0100,
    MODE_COMMENT = 11'b000_0000_1000,
    MODE_STR     = 11'b000_0001_0000,
    MODE_CHAR    = 11'b000_0010_0000,
    MODE_SLASH   = 11'b000_0100_0000,
    MODE_LT      = 11'b000_1000_0000,
    MODE_GT      = 11'b001_0000_0000,
    MODE_BANG    = 11'b010_0000_0000,
    MODE_EQ      = 11'b100_0000_0000
  } mode_t;

  localparam logic [7:0] CH_BACKTICK = 8'h60;

  mode_t       mode_r, mode_nxt;
  logic        qb_r, qb_nxt;
  logic        esc_r, esc_nxt;
  logic [47:0] kbuf_r, kbuf_nxt;
  logic [2:0]  len_r, len_nxt;

  logic [7:0]  c;
  logic        c_alpha, c_digit;

  mode_t       st_mode;
  logic        st_qb;
  logic [47:0] st_kbuf;
  logic [2:0]  st_len;
  logic        st_emit;
  logic [5:0]  st_kind;
  logic [7:0]  st_val;

  logic [5:0]  op_single, op_pair;

  logic [5:0]  rk [SCT_MAX_RES];
  logic [7:0]  rv [SCT_MAX_RES];
  logic [1:0]  n;

  assign c       = item.source_byte;
  assign c_alpha = c inside {["a":"z"], ["A":"Z"]};
  assign c_digit = c inside {["0":"9"]};

  // fresh token start from idle
  always_comb begin
    st_mode = MODE_IDLE;
    st_qb   = qb_r;
    st_kbuf = '0;
    st_len  = '0;
    st_emit = 1'b0;
    st_kind = K_LEXEME;
    st_val  = '0;
    if (c_alpha) begin
      st_mode       = MODE_IDENT;
      st_kbuf[7:0]  = c;
      st_len        = 3'd1;
      st_emit       = 1'b1;
      st_val        = c;
    end else if (c_digit) begin
      st_mode = MODE_NUM;
      st_emit = 1'b1;
      st_val  = c;
    end else begin
      case (c)
        "+": begin st_emit = 1'b1; st_kind = K_PLUS; end
        "-": begin st_emit = 1'b1; st_kind = K_MINUS; end
        "*": begin st_emit = 1'b1; st_kind = K_STAR; end
        "(": begin st_emit = 1'b1; st_kind = K_LPAREN; end
        ")": begin st_emit = 1'b1; st_kind = K_RPAREN; end
        "{": begin st_emit = 1'b1; st_kind = K_LBRACE; end
        "}": begin st_emit = 1'b1; st_kind = K_RBRACE; end
        ".": begin st_emit = 1'b1; st_kind = K_DOT; end
        ":": begin st_emit = 1'b1; st_kind = K_COLON; end
        ";": begin st_emit = 1'b1; st_kind = K_SEMI; end
        "/": st_mode = MODE_SLASH;
        "<": st_mode = MODE_LT;
        ">": st_mode = MODE_GT;
        "!": st_mode = MODE_BANG;
        "=": st_mode = MODE_EQ;
        "'": st_mode = MODE_CHAR;
        "\"": begin st_mode = MODE_STR; st_qb = 1'b0; end
        CH_BACKTICK: begin st_mode = MODE_STR; st_qb = 1'b1; end
        default: ;
      endcase
    end
  end

  // one-character and two-character operator kinds of a held operator
  always_comb begin
    case (mode_r)
      MODE_SLASH: begin op_single = K_SLASH;   op_pair = K_SLASH; end
      MODE_LT:    begin op_single = K_LESS;    op_pair = K_LESS_EQ; end
      MODE_GT:    begin op_single = K_GREATER; op_pair = K_GREATER_EQ; end
      MODE_BANG:  begin op_single = K_NOT;     op_pair = K_NOT_EQ; end
      default:    begin op_single = K_EQUAL;   op_pair = K_EQUAL_EQ; end
    endcase
  end

  always_comb begin
    logic [7:0] term;
    logic [7:0] v;
    logic [5:0] fk;
    mode_nxt = mode_r;
    qb_nxt   = qb_r;
    esc_nxt  = esc_r;
    kbuf_nxt = kbuf_r;
    len_nxt  = len_r;
    n        = '0;
    term     = "\"";
    v        = c;
    fk       = K_LEXEME;
    for (int i = 0; i < SCT_MAX_RES; i++) begin
      rk[i] = K_LEXEME;
      rv[i] = '0;
    end

    case (mode_r)
      MODE_IDENT: begin
        if (c_alpha || c_digit || c == "_") begin
          for (int i = 0; i < 6; i++) begin
            if (len_r == 3'(i)) begin
              kbuf_nxt[8*i +: 8] = c;
            end
          end
          if (len_r != 3'd7) begin
            len_nxt = len_r + 3'd1;
          end
          rk[n] = K_LEXEME; rv[n] = c; n = n + 2'd1;
        end else begin
          rk[n] = ident_kind(kbuf_r, len_r); n = n + 2'd1;
          mode_nxt = st_mode; qb_nxt = st_qb; esc_nxt = 1'b0;
          kbuf_nxt = st_kbuf; len_nxt = st_len;
          if (st_emit) begin
            rk[n] = st_kind; rv[n] = st_val; n = n + 2'd1;
          end
        end
      end
      MODE_NUM: begin
        if (c_digit) begin
          rk[n] = K_LEXEME; rv[n] = c; n = n + 2'd1;
        end else begin
          rk[n] = K_NUMBER; n = n + 2'd1;
          mode_nxt = st_mode; qb_nxt = st_qb; esc_nxt = 1'b0;
          kbuf_nxt = st_kbuf; len_nxt = st_len;
          if (st_emit) begin
            rk[n] = st_kind; rv[n] = st_val; n = n + 2'd1;
          end
        end
      end
      MODE_COMMENT: begin
        if (c == "\n") begin
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_STR, MODE_CHAR: begin
        if (esc_r) begin
          case (c)
            "n":     v = 8'd10;
            "b":     v = 8'd8;
            "t":     v = 8'd9;
            default: v = c;
          endcase
          esc_nxt = 1'b0;
          if (len_r != 3'd7) begin
            len_nxt = len_r + 3'd1;
          end
          rk[n] = K_LEXEME; rv[n] = v; n = n + 2'd1;
        end else if (c == "\\") begin
          esc_nxt = 1'b1;
        end else begin
          if (mode_r == MODE_CHAR) begin
            term = "'";
          end else if (qb_r) begin
            term = CH_BACKTICK;
          end
          if (c == term) begin
            if (mode_r == MODE_CHAR) begin
              fk = (len_r > 3'd1) ? K_ERROR : K_CHAR;
            end else begin
              fk = K_STRING;
            end
            mode_nxt = MODE_IDLE;
            kbuf_nxt = '0;
            len_nxt  = '0;
            esc_nxt  = 1'b0;
            rk[n] = fk; n = n + 2'd1;
          end else begin
            if (len_r != 3'd7) begin
              len_nxt = len_r + 3'd1;
            end
            rk[n] = K_LEXEME; rv[n] = c; n = n + 2'd1;
          end
        end
      end
      MODE_SLASH: begin
        if (c == "/") begin
          mode_nxt = MODE_COMMENT;
        end else begin
          rk[n] = K_SLASH; n = n + 2'd1;
          mode_nxt = st_mode; qb_nxt = st_qb; esc_nxt = 1'b0;
          kbuf_nxt = st_kbuf; len_nxt = st_len;
          if (st_emit) begin
            rk[n] = st_kind; rv[n] = st_val; n = n + 2'd1;
          end
        end
      end
      MODE_LT, MODE_GT, MODE_BANG, MODE_EQ: begin
        if (c == "=") begin
          rk[n] = op_pair; n = n + 2'd1;
          mode_nxt = MODE_IDLE;
        end else begin
          rk[n] = op_single; n = n + 2'd1;
          mode_nxt = st_mode; qb_nxt = st_qb; esc_nxt = 1'b0;
          kbuf_nxt = st_kbuf; len_nxt = st_len;
          if (st_emit) begin
            rk[n] = st_kind; rv[n] = st_val; n = n + 2'd1;
          end
        end
      end
      default: begin
        mode_nxt = st_mode; qb_nxt = st_qb; esc_nxt = 1'b0;
        kbuf_nxt = st_kbuf; len_nxt = st_len;
        if (st_emit) begin
          rk[n] = st_kind; rv[n] = st_val; n = n + 2'd1;
        end
      end
    endcase

    // flush on the last source byte
    if (item.final_byte) begin
      case (mode_nxt)
        MODE_IDENT: begin rk[n] = ident_kind(kbuf_nxt, len_nxt); n = n + 2'd1; end
        MODE_NUM:   begin rk[n] = K_NUMBER; n = n + 2'd1; end
        MODE_STR, MODE_CHAR: begin rk[n] = K_ERROR; n = n + 2'd1; end
        MODE_SLASH: begin rk[n] = K_SLASH; n = n + 2'd1; end
        MODE_LT:    begin rk[n] = K_LESS; n = n + 2'd1; end
        MODE_GT:    begin rk[n] = K_GREATER; n = n + 2'd1; end
        MODE_BANG:  begin rk[n] = K_NOT; n = n + 2'd1; end
        MODE_EQ:    begin rk[n] = K_EQUAL; n = n + 2'd1; end
        default: ;
      endcase
      mode_nxt = MODE_IDLE;
      qb_nxt   = 1'b0;
      esc_nxt  = 1'b0;
      kbuf_nxt = '0;
      len_nxt  = '0;
    end
  end

  always_comb begin
    batch.count = n;
    for (int i = 0; i < SCT_MAX_RES; i++) begin
      batch.res[i].token_kind   = rk[i];
      batch.res[i].lexeme_value = rv[i];
      batch.res[i].last_of_run  = (n != 2'd0) && (2'(i) == n - 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      qb_r   <= 1'b0;
      esc_r  <= 1'b0;
      kbuf_r <= '0;
      len_r  <= '0;
    end else if (adv) begin
      mode_r <= mode_nxt;
      qb_r   <= qb_nxt;
      esc_r  <= esc_nxt;
      kbuf_r <= kbuf_nxt;
      len_r  <= len_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/sct_queue.sv
// result queue: takes a batch of up to three words, hands out one per cycle while out_stall is low
`default_nettype none

module sct_queue (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire sct_pkg::sct_batch_t        batch,
  input  wire logic                       out_stall,
  output logic                            out_valid,
  output sct_pkg::sct_out_t               out_word,
  output logic [sct_pkg::SCT_QCNT_W-1:0]  fill
);
  import sct_pkg::*;

  sct_out_t              mem_r [SCT_QUEUE_DEPTH];
  logic [SCT_QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [SCT_QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [SCT_QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [SCT_QCNT_W-1:0] push_cnt;
  logic                  pop;

  assign pop       = (cnt_r != '0) && !out_stall;
  assign push_cnt  = push ? SCT_QCNT_W'(batch.count) : '0;
  assign out_valid = (cnt_r != '0);
  assign out_word  = mem_r[rd_ptr_r];
  assign fill      = cnt_r;

  assign wr_ptr_nxt = wr_ptr_r + SCT_QPTR_W'(push_cnt);
  assign rd_ptr_nxt = rd_ptr_r + SCT_QPTR_W'(pop);
  assign cnt_nxt    = cnt_r + push_cnt - SCT_QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < SCT_MAX_RES; i++) begin
        if (2'(i) < batch.count) begin
          mem_r[wr_ptr_r + SCT_QPTR_W'(i)] <= batch.res[i];
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/source_code_tokenizer.sv
// top level of the source code tokenizer: input register, scanner, result queue
// path: input register, combinational scanner, result queue, whose head drives out_word
// throughput: one byte per cycle while out_stall is low and each byte yields at most
//   one word; bytes yielding two or three words stall the input while they drain
// the input register waits until the result queue has room for three words
// reset: synchronous active-low rst_n empties the input register and queue, scanner idle
`default_nettype none

module source_code_tokenizer (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire sct_pkg::sct_in_t in_word,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output sct_pkg::sct_out_t     out_word
);
  import sct_pkg::*;

  sct_in_t               item_r;
  logic                  valid_r, valid_nxt;
  logic                  room;
  logic                  adv;
  logic                  accept;
  logic [SCT_QCNT_W-1:0] fill;
  sct_batch_t            batch;

  assign room     = (fill <= SCT_QCNT_W'(SCT_QUEUE_DEPTH - SCT_MAX_RES));
  assign adv      = valid_r && room;
  assign in_stall = valid_r && !room;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_word;
    end
  end

  sct_lexer u_lexer (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (item_r),
    .batch (batch)
  );

  sct_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv),
    .batch     (batch),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .fill      (fill)
  );

endmodule

`default_nettype wire

>>> sv/sct_checker.sv
// port-level checks for the source code tokenizer and their binding
`default_nettype none

module sct_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire sct_pkg::sct_out_t out_word
);
  import sct_pkg::*;

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  // reset leaves no word pending
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // reset leaves the input side open
  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

  // token kinds stay within the defined range
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.token_kind <= K_ERROR)
    else $error("token kind out of range");

  // only lexeme words carry a character
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.token_kind != K_LEXEME) |-> out_word.lexeme_value == 8'd0)
    else $error("closing word carries a character");

endmodule

bind source_code_tokenizer sct_checker u_sct_checker (.*);

`default_nettype wire

>>> verif/sct_token_scoreboard.sv
// scoreboard for the tokenizer: predicts result words per source byte and checks the output
`timescale 1ns / 1ps

module sct_token_scoreboard (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  sct_pkg::sct_in_t  in_word,
  input  logic              out_valid,
  input  logic              out_stall,
  input  sct_pkg::sct_out_t out_word,
  output int                mismatches,
  output int                words_waiting,
  output int                bytes_taken,
  output int                words_checked
);
  import sct_pkg::*;

  typedef enum logic [3:0] {
    SM_IDLE, SM_NAME, SM_NUMBER, SM_COMMENT, SM_STRING, SM_CHARLIT,
    SM_SLASH, SM_LT, SM_GT, SM_BANG, SM_EQ
  } scan_state_t;

  localparam logic [7:0] CH_NL       = 8'h0a;
  localparam logic [7:0] CH_DQUOTE   = 8'h22;
  localparam logic [7:0] CH_QUOTE    = 8'h27;
  localparam logic [7:0] CH_BSLASH   = 8'h5c;
  localparam logic [7:0] CH_BACKTICK = 8'h60;

  string kw_names[SCT_NUM_KW] = '{"case", "const", "def", "if", "elseif", "else", "for",
    "fn", "switch", "while", "loop", "true", "false", "int", "char", "bool", "str"};

  scan_state_t scan_state;
  logic        backtick_quote;
  logic        escape_open;
  logic [47:0] name_text;
  logic [2:0]  name_len;
  sct_out_t    step_words[$];
  sct_out_t    pending_words[$];

  function automatic void put(input logic [5:0] kind, input logic [7:0] val);
    sct_out_t w;
    w.token_kind   = kind;
    w.lexeme_value = val;
    w.last_of_run  = 1'b0;
    step_words.push_back(w);
  endfunction

  function automatic void clear_name();
    name_text   = '0;
    name_len    = '0;
    escape_open = 1'b0;
  endfunction

  function automatic void reset_scanner();
    scan_state     = SM_IDLE;
    backtick_quote = 1'b0;
    clear_name();
  endfunction

  function automatic void grow_name(input logic [7:0] c);
    if (name_len < 3'd6) name_text[8*name_len +: 8] = c;
    if (name_len < 3'd7) name_len++;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [5:0] closing_kind_of_name();
    logic [5:0] kind;
    logic       same;
    kind = K_IDENT;
    if (name_len <= 3'd6) begin
      for (int k = 0; k < SCT_NUM_KW; k++) begin
        same = (kw_names[k].len() == int'(name_len));
        for (int i = 0; i < kw_names[k].len(); i++) begin
          if (kw_names[k][i] != name_text[8*i +: 8]) same = 1'b0;
        end
        if (same && kind == K_IDENT) kind = K_KW0 + 6'(k);
      end
    end
    return kind;
  endfunction

  function automatic logic [5:0] single_kind(input scan_state_t m);
    case (m)
      SM_SLASH: return K_SLASH;
      SM_LT:    return K_LESS;
      SM_GT:    return K_GREATER;
      SM_BANG:  return K_NOT;
      default:  return K_EQUAL;
    endcase
  endfunction

  function automatic void start_token(input logic [7:0] c);
    scan_state = SM_IDLE;
    clear_name();
    if (is_letter(c)) begin
      scan_state = SM_NAME;
      grow_name(c);
      put(K_LEXEME, c);
    end else if (is_digit(c)) begin
      scan_state = SM_NUMBER;
      put(K_LEXEME, c);
    end else begin
      case (c)
        "+": put(K_PLUS, 8'h00);
        "-": put(K_MINUS, 8'h00);
        "*": put(K_STAR, 8'h00);
        "(": put(K_LPAREN, 8'h00);
        ")": put(K_RPAREN, 8'h00);
        "{": put(K_LBRACE, 8'h00);
        "}": put(K_RBRACE, 8'h00);
        ".": put(K_DOT, 8'h00);
        ":": put(K_COLON, 8'h00);
        ";": put(K_SEMI, 8'h00);
        "/": scan_state = SM_SLASH;
        "<": scan_state = SM_LT;
        ">": scan_state = SM_GT;
        "!": scan_state = SM_BANG;
        "=": scan_state = SM_EQ;
        CH_QUOTE: scan_state = SM_CHARLIT;
        CH_DQUOTE: begin
          scan_state     = SM_STRING;
          backtick_quote = 1'b0;
        end
        CH_BACKTICK: begin
          scan_state     = SM_STRING;
          backtick_quote = 1'b1;
        end
        default: ;
      endcase
    end
  endfunction

  function automatic void tokenize_byte(input logic [7:0] c, input logic fin);
    logic [7:0] v;
    logic [7:0] term;
    logic [5:0] kind;
    step_words.delete();
    case (scan_state)
      SM_NAME: begin
        if (is_letter(c) || is_digit(c) || c == "_") begin
          grow_name(c);
          put(K_LEXEME, c);
        end else begin
          put(closing_kind_of_name(), 8'h00);
          start_token(c);
        end
      end
      SM_NUMBER: begin
        if (is_digit(c)) put(K_LEXEME, c);
        else begin
          put(K_NUMBER, 8'h00);
          start_token(c);
        end
      end
      SM_COMMENT: if (c == CH_NL) scan_state = SM_IDLE;
      SM_STRING, SM_CHARLIT: begin
        if (escape_open) begin
          escape_open = 1'b0;
          v = c;
          if (c == "n") v = 8'd10;
          else if (c == "b") v = 8'd8;
          else if (c == "t") v = 8'd9;
          if (name_len < 3'd7) name_len++;
          put(K_LEXEME, v);
        end else if (c == CH_BSLASH) begin
          escape_open = 1'b1;
        end else begin
          if (scan_state == SM_CHARLIT) term = CH_QUOTE;
          else term = backtick_quote ? CH_BACKTICK : CH_DQUOTE;
          if (c == term) begin
            kind = K_STRING;
            if (scan_state == SM_CHARLIT) kind = (name_len > 3'd1) ? K_ERROR : K_CHAR;
            scan_state = SM_IDLE;
            clear_name();
            put(kind, 8'h00);
          end else begin
            if (name_len < 3'd7) name_len++;
            put(K_LEXEME, c);
          end
        end
      end
      SM_SLASH: begin
        if (c == "/") scan_state = SM_COMMENT;
        else begin
          put(K_SLASH, 8'h00);
          start_token(c);
        end
      end
      SM_LT, SM_GT, SM_BANG, SM_EQ: begin
        if (c == "=") begin
          put(single_kind(scan_state) + 6'd1, 8'h00);
          scan_state = SM_IDLE;
        end else begin
          put(single_kind(scan_state), 8'h00);
          start_token(c);
        end
      end
      default: start_token(c);
    endcase
    if (fin) begin
      case (scan_state)
        SM_NAME:               put(closing_kind_of_name(), 8'h00);
        SM_NUMBER:             put(K_NUMBER, 8'h00);
        SM_STRING, SM_CHARLIT: put(K_ERROR, 8'h00);
        SM_SLASH, SM_LT, SM_GT, SM_BANG, SM_EQ: put(single_kind(scan_state), 8'h00);
        default: ;
      endcase
      reset_scanner();
    end
    if (step_words.size() > 0) step_words[step_words.size()-1].last_of_run = 1'b1;
    foreach (step_words[i]) pending_words.push_back(step_words[i]);
  endfunction

  always @(posedge clk) begin
    sct_out_t want;
    if (!rst_n) begin
      reset_scanner();
      pending_words.delete();
      mismatches    = 0;
      bytes_taken   = 0;
      words_checked = 0;
    end else begin
      if (out_valid && !out_stall) begin
        words_checked++;
        if (pending_words.size() == 0) begin
          $error("unexpected word: token_kind %0d, lexeme_value %0d, last_of_run %0d",
                 out_word.token_kind, out_word.lexeme_value, out_word.last_of_run);
          mismatches++;
        end else begin
          want = pending_words.pop_front();
          if (out_word.token_kind !== want.token_kind) begin
            $error("token_kind: expected %0d, got %0d", want.token_kind, out_word.token_kind);
            mismatches++;
          end
          if (out_word.lexeme_value !== want.lexeme_value) begin
            $error("lexeme_value: expected %0d, got %0d",
                   want.lexeme_value, out_word.lexeme_value);
            mismatches++;
          end
          if (out_word.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, got %0d", want.last_of_run, out_word.last_of_run);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        bytes_taken++;
        tokenize_byte(in_word.source_byte, in_word.final_byte);
      end
    end
    words_waiting = pending_words.size();
  end

endmodule

>>> verif/tb_source_code_tokenizer.sv
// testbench top for the tokenizer: clock, reset, byte stimulus, output stalls and verdict
`timescale 1ns / 1ps

module tb_source_code_tokenizer;
  import sct_pkg::*;

  localparam logic [7:0] CH_NL       = 8'h0a;
  localparam logic [7:0] CH_DQUOTE   = 8'h22;
  localparam logic [7:0] CH_QUOTE    = 8'h27;
  localparam logic [7:0] CH_BSLASH   = 8'h5c;
  localparam logic [7:0] CH_BACKTICK = 8'h60;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  sct_in_t  in_word;
  logic     out_valid;
  logic     out_stall;
  sct_out_t out_word;
  int       mismatches;
  int       words_waiting;
  int       bytes_taken;
  int       words_checked;
  bit       gaps_on;
  int       directed_bytes;

  logic [7:0] piece[$];
  string key_words[SCT_NUM_KW] = '{"case", "const", "def", "if", "elseif", "else", "for",
    "fn", "switch", "while", "loop", "true", "false", "int", "char", "bool", "str"};
  string op_chars = "+-*(){}.:;/<>!=";
  string spacing  = " \n\t_";

  source_code_tokenizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  sct_token_scoreboard u_scoreboard (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .mismatches    (mismatches),
    .words_waiting (words_waiting),
    .bytes_taken   (bytes_taken),
    .words_checked (words_checked)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // output back-pressure in random bursts while gaps are enabled
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 6) == 0) begin
        hold = $urandom_range(1, 9);
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic fin);
    int gap;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_word  <= '{source_byte: c, final_byte: fin};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range(97, 122)) : 8'($urandom_range(65, 90));
  endfunction

  function automatic logic [7:0] rand_name_char();
    case ($urandom_range(0, 5))
      0:       return 8'($urandom_range(48, 57));
      1:       return "_";
      default: return rand_letter();
    endcase
  endfunction

  // one literal character, plain or escaped, inside a quote of the given kind
  function automatic void push_literal_char(input logic [7:0] quote);
    logic [7:0] esc_set [5];
    esc_set = '{"n", "b", "t", quote, CH_BSLASH};
    if ($urandom_range(0, 2) == 0) begin
      piece.push_back(CH_BSLASH);
      piece.push_back($urandom_range(0, 1) ? esc_set[$urandom_range(0, 4)]
                                           : 8'($urandom_range(32, 126)));
    end else begin
      piece.push_back(8'($urandom_range(32, 126)));
    end
  endfunction

  // builds one source fragment; returns 0 for a single spacing character or random byte
  function automatic bit build_piece();
    string      kw;
    logic [7:0] quote;
    int         n;
    piece.delete();
    case ($urandom_range(0, 11))
      0, 1, 2: begin
        kw = key_words[$urandom_range(0, SCT_NUM_KW - 1)];
        for (int i = 0; i < kw.len(); i++) piece.push_back(kw[i]);
        if ($urandom_range(0, 3) == 0) piece.push_back(rand_name_char());
      end
      3: begin
        piece.push_back(rand_letter());
        n = $urandom_range(0, 8);
        repeat (n) piece.push_back(rand_name_char());
      end
      4: begin
        n = $urandom_range(1, 4);
        repeat (n) piece.push_back(8'($urandom_range(48, 57)));
      end
      5, 6: begin
        piece.push_back(op_chars[$urandom_range(0, op_chars.len() - 1)]);
        if ($urandom_range(0, 2) == 0) piece.push_back("=");
      end
      7: begin
        piece.push_back("/");
        piece.push_back("/");
        n = $urandom_range(0, 4);
        repeat (n) piece.push_back(8'($urandom_range(32, 126)));
        piece.push_back(CH_NL);
      end
      8: begin
        quote = $urandom_range(0, 1) ? CH_DQUOTE : CH_BACKTICK;
        piece.push_back(quote);
        n = $urandom_range(0, 5);
        repeat (n) push_literal_char(quote);
        if ($urandom_range(0, 5) != 0) piece.push_back(quote);
      end
      9: begin
        piece.push_back(CH_QUOTE);
        n = $urandom_range(0, 3);
        repeat (n) push_literal_char(CH_QUOTE);
        if ($urandom_range(0, 5) != 0) piece.push_back(CH_QUOTE);
      end
      10: begin
        piece.push_back(spacing[$urandom_range(0, spacing.len() - 1)]);
        return 1'b0;
      end
      default: begin
        piece.push_back(8'($urandom_range(0, 255)));
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  initial begin
    string text;
    int    counted;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    gaps_on  = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // operator pairs, comment, escaped char literal, long char literal, open string at the end
    text = "x<=>=!==//c\n'\\n''ab'\"a\\\"b";
    for (int i = 0; i < text.len(); i++) send_byte(text[i], 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    directed_bytes = text.len() + 2;

    counted = directed_bytes;
    while (counted < 280) begin
      gaps_on = (counted < 190) ? ($urandom_range(0, 3) != 0) : 1'b0;
      void'(build_piece());
      counted += piece.size();
      foreach (piece[i]) send_byte(piece[i], $urandom_range(0, 29) == 0);
    end
    in_valid <= 1'b0;

    while (words_waiting != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("source bytes sent: %0d (%0d directed), result words checked: %0d",
             bytes_taken, directed_bytes, words_checked);
    $display("covered operators, keywords, names, numbers, comments, literals, escapes");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
